// ===== hdl/srle_pkg.sv =====
// ----------------------------------------------------------------------------
// srle_pkg
// Shared types, codes and helpers of the run-length row decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [6:0]  COUNT_MASK  = 7'h7F;
    localparam int unsigned KIND_BIT    = 7;
    localparam logic [15:0] TOTAL_MAX   = 16'hFFFF;

    localparam logic        MODE_RESET  = 1'b1;
    localparam logic [15:0] WIDTH_RESET = 16'h0100;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUN     = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        K_LITERAL = 2'd0,
        K_VERBATIM = 2'd1,
        K_RUN     = 2'd2,
        K_ROW_END = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [6:0] count;
    } t_cmd;

    function automatic logic [15:0] sat_add(input logic [15:0] total,
                                            input logic [1:0] inc);
        logic [16:0] sum;
        sum = {1'b0, total} + {15'd0, inc};
        return sum[16] ? TOTAL_MAX : sum[15:0];
    endfunction

endpackage

// ===== hdl/srle_front.sv =====
// ----------------------------------------------------------------------------
// srle_front
// Classifies incoming bytes by decode phase and issues commands.
// ----------------------------------------------------------------------------
module srle_front
    import srle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_storage_mode,
    input  logic       i_accept,
    input  logic [7:0] i_stream_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    t_phase     r_phase, n_phase;
    logic [6:0] r_lit_left, n_lit_left;
    logic [6:0] r_run_len, n_run_len;
    logic [6:0] byte_count;

    assign byte_count = i_stream_byte[6:0] & COUNT_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase    <= PH_CONTROL;
            r_lit_left <= '0;
            r_run_len  <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_lit_left <= n_lit_left;
            r_run_len  <= n_run_len;
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_lit_left = r_lit_left;
        n_run_len  = r_run_len;
        if (i_storage_mode) begin
            case (r_phase)
                PH_LITERAL: begin
                    n_lit_left = (r_lit_left - 7'd1) & COUNT_MASK;
                    if (n_lit_left == 7'd0) begin
                        n_phase = PH_CONTROL;
                    end
                end
                PH_RUN: begin
                    n_run_len = '0;
                    n_phase   = PH_CONTROL;
                end
                default: begin
                    if (byte_count == 7'd0) begin
                        n_phase    = PH_CONTROL;
                        n_lit_left = '0;
                        n_run_len  = '0;
                    end else if (i_stream_byte[KIND_BIT]) begin
                        n_lit_left = byte_count;
                        n_phase    = PH_LITERAL;
                    end else begin
                        n_run_len = byte_count;
                        n_phase   = PH_RUN;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd.kind  = K_LITERAL;
        o_cmd.value = i_stream_byte;
        o_cmd.count = 7'd1;
        if (!i_storage_mode) begin
            o_cmd_valid = i_accept;
            o_cmd.kind  = K_VERBATIM;
        end else begin
            case (r_phase)
                PH_LITERAL: begin
                    o_cmd_valid = i_accept;
                end
                PH_RUN: begin
                    o_cmd_valid = i_accept && (r_run_len != 7'd0);
                    o_cmd.kind  = K_RUN;
                    o_cmd.count = r_run_len;
                end
                default: begin
                    // control byte: only a zero count makes a result
                    o_cmd_valid = i_accept && (byte_count == 7'd0);
                    o_cmd.kind  = K_ROW_END;
                    o_cmd.value = '0;
                    o_cmd.count = '0;
                end
            endcase
        end
    end

endmodule

// ===== hdl/srle_queue.sv =====
// ----------------------------------------------------------------------------
// srle_queue
// Small command queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module srle_queue
    import srle_pkg::*;
#(
    parameter int unsigned P_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_cmd i_wr_data,
    input  logic i_rd_en,
    output t_cmd o_rd_data,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(P_DEPTH - 1);

    t_cmd          r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_fire, rd_fire;

    assign o_full    = (r_count == CW'(P_DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + CW'(1);
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/srle_back.sv =====
// ----------------------------------------------------------------------------
// srle_back
// Expands commands into pixel results, keeps the row's pixel total, and holds
// the output register.
// ----------------------------------------------------------------------------
module srle_back
    import srle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic [15:0] i_row_width,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_avail,
    output logic        o_cmd_take,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [7:0]  o_pixel_first,
    output logic [7:0]  o_pixel_second,
    output logic [1:0]  o_pixel_count,
    output logic        o_row_end,
    output logic [15:0] o_row_total
);

    logic        r_active, n_active;
    logic [6:0]  r_left, n_left;
    logic [15:0] r_pixels, n_pixels;
    logic        r_out_valid;
    logic [7:0]  r_first, r_second, n_first, n_second;
    logic [1:0]  r_count, n_count;
    logic        r_end, n_end;
    logic [15:0] r_total, n_total;

    logic        advance;
    logic [6:0]  left;
    logic [15:0] width_eff;
    logic [15:0] sum_one;

    assign advance   = i_cmd_avail && (!r_out_valid || i_pop);
    assign left      = r_active ? r_left : i_cmd.count;
    assign width_eff = (i_row_width == 16'd0) ? 16'd1 : i_row_width;
    assign sum_one   = sat_add(r_pixels, 2'd1);

    always_comb begin
        n_active   = r_active;
        n_left     = r_left;
        n_pixels   = r_pixels;
        n_first    = i_cmd.value;
        n_second   = '0;
        n_count    = 2'd1;
        n_end      = 1'b0;
        n_total    = sum_one;
        o_cmd_take = 1'b0;
        case (i_cmd.kind)
            K_LITERAL: begin
                n_pixels   = sum_one;
                o_cmd_take = advance;
            end
            K_VERBATIM: begin
                n_end      = (sum_one >= width_eff);
                n_pixels   = n_end ? 16'd0 : sum_one;
                o_cmd_take = advance;
            end
            K_RUN: begin
                if (left >= 7'd2) begin
                    n_second = i_cmd.value;
                    n_count  = 2'd2;
                    n_total  = sat_add(r_pixels, 2'd2);
                    n_left   = left - 7'd2;
                end else begin
                    n_left = '0;
                end
                n_pixels = n_total;
                // hold the command until the run is drained
                n_active   = (n_left != 7'd0);
                o_cmd_take = advance && (n_left == 7'd0);
            end
            default: begin
                n_first    = '0;
                n_count    = 2'd0;
                n_end      = 1'b1;
                n_total    = r_pixels;
                n_pixels   = '0;
                o_cmd_take = advance;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_active    <= 1'b0;
            r_left      <= '0;
            r_pixels    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_active    <= n_active;
                r_left      <= n_left;
                r_pixels    <= n_pixels;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_count  <= n_count;
            r_end    <= n_end;
            r_total  <= n_total;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_pixel_first  = r_first;
    assign o_pixel_second = r_second;
    assign o_pixel_count  = r_count;
    assign o_row_end      = r_end;
    assign o_row_total    = r_total;

endmodule

// ===== hdl/sgi_rle_row_decoder_top.sv =====
// Path: a byte's result passes through the command queue, then the output register.
// Throughput: literal and verbatim bytes go at one per cycle unless the queue is
// full or results are not popped; while popped, a run is expanded two pixels per
// cycle (one for an odd tail) and the command queue takes bytes until it fills.
// Reset: synchronous, active low; mode returns to run-length and width to 256.
// ----------------------------------------------------------------------------
// sgi_rle_row_decoder_top
// Row decoder for run-length or verbatim planar image channel rows.
// ----------------------------------------------------------------------------
module sgi_rle_row_decoder_top
    import srle_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_stream_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_pixel_first,
    output logic [7:0]  o_pixel_second,
    output logic [1:0]  o_pixel_count,
    output logic        o_row_end,
    output logic [15:0] o_row_total
);

    logic        r_storage_mode;
    logic [15:0] r_row_width;
    logic        mode_write;
    logic        in_accept;
    logic        cmd_valid;
    t_cmd        cmd_in, cmd_head;
    logic        q_empty;
    logic        cmd_take;

    assign mode_write = i_cfg_we && (i_cfg_index == REG_MODE);
    assign in_accept  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_storage_mode <= MODE_RESET;
            r_row_width    <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MODE) begin
                r_storage_mode <= i_cfg_data[0];
            end else if (i_cfg_index == REG_WIDTH) begin
                r_row_width <= i_cfg_data;
            end
        end
    end

    srle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (mode_write),
        .i_storage_mode (r_storage_mode),
        .i_accept       (in_accept),
        .i_stream_byte  (i_stream_byte),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd_in)
    );

    srle_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cmd_valid),
        .i_wr_data (cmd_in),
        .i_rd_en   (cmd_take),
        .o_rd_data (cmd_head),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    srle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (mode_write),
        .i_row_width    (r_row_width),
        .i_cmd          (cmd_head),
        .i_cmd_avail    (!q_empty),
        .o_cmd_take     (cmd_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_count  (o_pixel_count),
        .o_row_end      (o_row_end),
        .o_row_total    (o_row_total)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_pixel_count != 2'd3)
        else $error("pixel count out of range");

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_pixel_count == 2'd0) |-> (o_row_end && o_pixel_first == 8'd0))
        else $error("empty result is not a row end");

    a_verbatim_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !r_storage_mode) |-> o_pixel_count == 2'd1)
        else $error("verbatim result without exactly one pixel");

    a_second_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_pixel_count != 2'd2) |-> o_pixel_second == 8'd0)
        else $error("second pixel set on a short result");

endmodule
